FILE: hw/rtl/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants for the Wilder RSI block
// Widths, payload structs and sequencer states used across the RSI design.
// ----------------------------------------------------------------------------
package wrsi_pkg;

  // field widths
  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned PERIOD_W   = 7;
  localparam int unsigned RSI_W      = 15;
  localparam int unsigned AVG_W      = 48;

  // period limits and reset value
  localparam int unsigned MAX_PERIOD   = 64;
  localparam int unsigned MIN_PERIOD   = 2;
  localparam int unsigned PERIOD_RESET = 14;

  // full-scale result, 100 * 256
  localparam int unsigned RSI_FULL = 25600;

  // divider sizing
  localparam int unsigned DIVD_W = AVG_W + PERIOD_W;     // smoothing dividend
  localparam int unsigned REM_W  = AVG_W + 1;            // remainder / divisor
  localparam int unsigned NUM_W  = AVG_W + RSI_W;        // ratio numerator
  localparam int unsigned STEP_W = $clog2(AVG_W + 1);

  typedef struct packed {
    logic [PRICE_BITS-1:0] close_price;
    logic                  restart;
  } in_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi_value;
    logic             rsi_valid;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_G,
    ST_DIV_G,
    ST_LOAD_L,
    ST_DIV_L,
    ST_LOAD_R,
    ST_DIV_R,
    ST_OUT
  } state_e;

endpackage

FILE: hw/rtl/wilder_rsi_indicator_top.sv
// ----------------------------------------------------------------------------
// wilder_rsi_indicator_top: Wilder relative strength index over closing prices
// Keeps the previous price and Wilder-smoothed average gain and loss, and
// returns one result per price, RSI * 256 once seeded, using one shared restoring divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+---------------------
//  in      | input     | in_valid_i / in_ready_o          | close_price, restart
//  out     | output    | out_valid_o / out_ready_i        | rsi_value, rsi_valid
//  cfg     | input     | cfg_valid_i / cfg_ready_o        | period (7 bits)
//
//  A first price, a restart or a seeding price that does not end seeding can
//  hand over its result in the cycle after the transfer. A price that ends
//  seeding or is smoothed needs a load state and 48 steps for each average,
//  a load state and 15 steps for the ratio (skipped when the average loss is
//  zero), all on the one restoring divider, then the result state.
//  The input is ready only when idle; a stalled output holds the block.
//  Reset clears the price history and sets the period to 14.
//
module wilder_rsi_indicator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wrsi_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wrsi_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_data_i
);
  import wrsi_pkg::*;

  // control and history state
  state_e                state_q, state_d;
  logic [PERIOD_W-1:0]   period_q, period_d;
  logic [PRICE_BITS-1:0] prev_q, prev_d;
  logic [PERIOD_W-1:0]   count_q, count_d;
  logic [AVG_W-1:0]      avg_g_q, avg_g_d;
  logic [AVG_W-1:0]      avg_l_q, avg_l_d;
  logic                  started_q, started_d;

  // per-item working registers
  logic [PERIOD_W-1:0]   p_q, p_d;
  logic                  smooth_q, smooth_d;
  logic [PRICE_BITS-1:0] x_gain_q, x_gain_d;
  logic [PRICE_BITS-1:0] x_loss_q, x_loss_d;
  out_t                  out_q, out_d;

  // divider registers
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [AVG_W-1:0]      shreg_q, shreg_d;
  logic [REM_W-1:0]      divisor_q, divisor_d;
  logic [STEP_W-1:0]     step_q, step_d;

  // combinational helpers
  logic [PERIOD_W-1:0]   p_eff;
  logic                  in_xfer;
  logic [PRICE_BITS-1:0] price;
  logic                  rising;
  logic [PRICE_BITS-1:0] gain, loss;
  logic [PERIOD_W-1:0]   count_inc;
  logic [PERIOD_W-1:0]   pm1;
  logic [AVG_W-1:0]      mul_avg;
  logic [PRICE_BITS-1:0] mul_x;
  logic [DIVD_W-1:0]     dividend;
  logic [NUM_W-1:0]      numer;
  logic [REM_W+1:0]      trial;
  logic                  q_bit;
  logic [REM_W-1:0]      rem_step;
  logic [AVG_W-1:0]      shreg_step;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;

  // period in use, clamped to the legal range
  always_comb begin
    p_eff = period_q;
    if (period_q < PERIOD_W'(MIN_PERIOD)) begin
      p_eff = PERIOD_W'(MIN_PERIOD);
    end else if (period_q > PERIOD_W'(MAX_PERIOD)) begin
      p_eff = PERIOD_W'(MAX_PERIOD);
    end
  end

  // price change split into gain and loss
  assign price     = in_data_i.close_price;
  assign rising    = (price > prev_q);
  assign gain      = rising ? (price - prev_q) : '0;
  assign loss      = rising ? '0 : (prev_q - price);
  assign count_inc = count_q + PERIOD_W'(1);

  // shared multiplier for the smoothing dividend
  assign pm1      = p_q - PERIOD_W'(1);
  assign mul_avg  = (state_q == ST_LOAD_G) ? avg_g_q : avg_l_q;
  assign mul_x    = (state_q == ST_LOAD_G) ? x_gain_q : x_loss_q;
  assign dividend = smooth_q
                    ? (DIVD_W'(mul_avg) * DIVD_W'(pm1) + DIVD_W'(mul_x))
                    : DIVD_W'(mul_avg);

  // ratio numerator, gain * 25600
  assign numer = NUM_W'(avg_g_q) * NUM_W'(RSI_FULL);

  // one restoring divider step
  assign trial      = {1'b0, rem_q, shreg_q[AVG_W-1]} - {2'b00, divisor_q};
  assign q_bit      = ~trial[REM_W+1];
  assign rem_step   = q_bit ? trial[REM_W-1:0] : {rem_q[REM_W-2:0], shreg_q[AVG_W-1]};
  assign shreg_step = {shreg_q[AVG_W-2:0], q_bit};

  // sequencer and datapath next values
  always_comb begin
    state_d   = state_q;
    period_d  = period_q;
    prev_d    = prev_q;
    count_d   = count_q;
    avg_g_d   = avg_g_q;
    avg_l_d   = avg_l_q;
    started_d = started_q;
    p_d       = p_q;
    smooth_d  = smooth_q;
    x_gain_d  = x_gain_q;
    x_loss_d  = x_loss_q;
    out_d     = out_q;
    rem_d     = rem_q;
    shreg_d   = shreg_q;
    divisor_d = divisor_q;
    step_d    = step_q;

    // configuration write
    if (cfg_valid_i) begin
      period_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          prev_d   = price;
          p_d      = p_eff;
          x_gain_d = gain;
          x_loss_d = loss;
          if (in_data_i.restart || !started_q) begin
            // first price of a series
            count_d   = '0;
            avg_g_d   = '0;
            avg_l_d   = '0;
            started_d = 1'b1;
            out_d     = '0;
            state_d   = ST_OUT;
          end else if (count_q < p_eff) begin
            // seeding: accumulate sums
            avg_g_d  = avg_g_q + AVG_W'(gain);
            avg_l_d  = avg_l_q + AVG_W'(loss);
            count_d  = count_inc;
            smooth_d = 1'b0;
            if (count_inc >= p_eff) begin
              state_d = ST_LOAD_G;
            end else begin
              out_d   = '0;
              state_d = ST_OUT;
            end
          end else begin
            smooth_d = 1'b1;
            state_d  = ST_LOAD_G;
          end
        end
      end

      ST_LOAD_G, ST_LOAD_L: begin
        rem_d     = REM_W'(dividend[DIVD_W-1:AVG_W]);
        shreg_d   = dividend[AVG_W-1:0];
        divisor_d = REM_W'(p_q);
        step_d    = STEP_W'(AVG_W);
        state_d   = (state_q == ST_LOAD_G) ? ST_DIV_G : ST_DIV_L;
      end

      ST_DIV_G, ST_DIV_L: begin
        rem_d   = rem_step;
        shreg_d = shreg_step;
        step_d  = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          if (state_q == ST_DIV_G) begin
            avg_g_d = shreg_step;
            state_d = ST_LOAD_L;
          end else begin
            avg_l_d = shreg_step;
            state_d = ST_LOAD_R;
          end
        end
      end

      ST_LOAD_R: begin
        if (avg_l_q == '0) begin
          out_d.rsi_value = RSI_W'(RSI_FULL);
          out_d.rsi_valid = 1'b1;
          state_d         = ST_OUT;
        end else begin
          rem_d     = REM_W'(numer[NUM_W-1:RSI_W]);
          shreg_d   = {numer[RSI_W-1:0], {(AVG_W-RSI_W){1'b0}}};
          divisor_d = REM_W'(avg_g_q) + REM_W'(avg_l_q);
          step_d    = STEP_W'(RSI_W);
          state_d   = ST_DIV_R;
        end
      end

      ST_DIV_R: begin
        rem_d   = rem_step;
        shreg_d = shreg_step;
        step_d  = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          out_d.rsi_value = shreg_step[RSI_W-1:0];
          out_d.rsi_valid = 1'b1;
          state_d         = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      period_q  <= PERIOD_W'(PERIOD_RESET);
      prev_q    <= '0;
      count_q   <= '0;
      avg_g_q   <= '0;
      avg_l_q   <= '0;
      started_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      period_q  <= period_d;
      prev_q    <= prev_d;
      count_q   <= count_d;
      avg_g_q   <= avg_g_d;
      avg_l_q   <= avg_l_d;
      started_q <= started_d;
      step_q    <= step_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    smooth_q  <= smooth_d;
    x_gain_q  <= x_gain_d;
    x_loss_q  <= x_loss_d;
    out_q     <= out_d;
    rem_q     <= rem_d;
    shreg_q   <= shreg_d;
    divisor_q <= divisor_d;
  end

endmodule
